FILE: design/pfa_pkg.sv
// Shared types and constants for the partition fit allocator.
// Used by pfa_cell and partition_fit_allocator_unit; no dependencies.
package pfa_pkg;

  localparam int SizeW    = 16;   // request and partition size as seen on the ports
  localparam int IdxW     = 5;    // partition index, also scan count (at most 31)
  localparam int CntW     = 5;    // free partition count
  localparam int SumW     = 20;   // unused space
  localparam int UsedW    = 21;   // used space, two's complement
  localparam int PageW    = 16;   // request counter
  localparam int SlotW    = 4;    // slot number and slot index fields
  localparam int CfgIdxW  = 4;
  localparam int InDataW  = 24;
  localparam int OutDataW = 104;

  localparam logic [CfgIdxW-1:0] CfgTotalMem   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgSlotsInUse = 4'd1;

  typedef enum logic [2:0] {
    OpLoad   = 3'd0,
    OpFirst  = 3'd1,
    OpBest   = 3'd2,
    OpWorst  = 3'd3,
    OpNext   = 3'd4,
    OpReport = 3'd5
  } pfa_op_e;

  // Broadcast to every cell; op, req and start are held steady while a token runs down the chain
  typedef struct packed {
    pfa_op_e           op;
    logic [SizeW-1:0]  req;
    logic [IdxW-1:0]   n;
    logic [IdxW-1:0]   start;
  } pfa_scan_t;

  // Single-partition update: load or allocation commit
  typedef struct packed {
    logic              en;
    logic              set_taken;
    logic [IdxW-1:0]   idx;
    logic [SizeW-1:0]  size;
  } pfa_wr_t;

  // Search token: main candidate, wrap candidate for next fit, report sums
  typedef struct packed {
    logic              a_hit;
    logic [IdxW-1:0]   a_idx;
    logic [SizeW-1:0]  a_size;
    logic              w_hit;
    logic [IdxW-1:0]   w_idx;
    logic [SizeW-1:0]  w_size;
    logic [CntW-1:0]   free_cnt;
    logic [SumW-1:0]   unused;
  } pfa_rec_t;

endpackage

FILE: design/pfa_cell.sv
// One partition of the allocator chain: holds size and taken flag, and
// refines the search token passing through it. Depends on pfa_pkg.
module pfa_cell import pfa_pkg::*; #(
  parameter int IDX       = 0,
  parameter int SIZE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pfa_scan_t scan_i,
  input  pfa_wr_t   wr_i,
  input  logic      tok_valid_i,
  input  pfa_rec_t  tok_i,
  output logic      tok_valid_o,
  output pfa_rec_t  tok_o
);

  // Cells at 31 and above are never scanned nor written
  localparam bit              Reach = (IDX < 31);
  localparam logic [IdxW-1:0] Idx5  = Reach ? IdxW'(IDX) : 5'd31;

  logic [SIZE_BITS-1:0] size_q;
  logic                 taken_q;
  logic                 tok_valid_q;
  pfa_rec_t             tok_q, rec_d;
  logic [SizeW-1:0]     size_w;
  logic                 active, fit;

  assign size_w = SizeW'(size_q);
  assign active = Reach && (Idx5 < scan_i.n);
  assign fit    = active && !taken_q && (size_w >= scan_i.req);

  always_comb begin
    rec_d = tok_i;
    if (active) begin
      if (!taken_q) rec_d.free_cnt = tok_i.free_cnt + CntW'(1);
      rec_d.unused = tok_i.unused + SumW'(size_w);
    end
    case (scan_i.op)
      OpFirst, OpNext: begin
        if (fit && !tok_i.a_hit && (Idx5 >= scan_i.start)) begin
          rec_d.a_hit  = 1'b1;
          rec_d.a_idx  = Idx5;
          rec_d.a_size = size_w;
        end
        // first fit overall, taken when nothing turns up at or after the start
        if (fit && !tok_i.w_hit) begin
          rec_d.w_hit  = 1'b1;
          rec_d.w_idx  = Idx5;
          rec_d.w_size = size_w;
        end
      end
      OpBest: begin
        if (fit && (!tok_i.a_hit || (size_w < tok_i.a_size))) begin
          rec_d.a_hit  = 1'b1;
          rec_d.a_idx  = Idx5;
          rec_d.a_size = size_w;
        end
      end
      OpWorst: begin
        if (fit && (!tok_i.a_hit || (size_w > tok_i.a_size))) begin
          rec_d.a_hit  = 1'b1;
          rec_d.a_idx  = Idx5;
          rec_d.a_size = size_w;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= '0;
      taken_q     <= 1'b0;
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
      if (wr_i.en && Reach && (wr_i.idx == Idx5)) begin
        size_q  <= SIZE_BITS'(wr_i.size);
        taken_q <= wr_i.set_taken;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid_i) tok_q <= rec_d;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

FILE: design/partition_fit_allocator_unit.sv
// Channel   | Dir | Handshake                  | Payload
// s_axis    | in  | s_axis_tvalid/tready       | tuser: operation; tdata: size, slot
// m_axis    | out | m_axis_tvalid/tready       | tuser: found; tdata: result fields
// cfg       | in  | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
// Allocate and report items pass from idle through setup into the scan: the
// search token steps through one cell per cycle. For next fit, setup first
// folds last_slot+1 below the scan count by repeated subtraction.
// Load and no-op items go straight from idle to done. Reset clears every partition at once.
// A finished result waits in the output register while the next item is taken.
// Top level of the partition fit allocator; depends on pfa_pkg and pfa_cell.
module partition_fit_allocator_unit import pfa_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] size_value, [19:16] slot_number, [23:20] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [2:0] operation
  input  logic [2:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [3:0] slot_index, [19:4] original_size, [35:20] remaining_size,
  // [51:36] page_number, [56:52] free_slots, [76:57] unused_space,
  // [97:77] used_space, [103:98] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] found
  output logic                m_axis_tuser,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSetup = 2'd1;
  localparam logic [1:0] StScan  = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  localparam logic [IdxW-1:0] SlotCap = (SLOTS >= 31) ? 5'd31 : IdxW'(SLOTS);

  logic [1:0]          state_q, state_d;
  pfa_op_e             op_q, op_d, op_in;
  logic [SizeW-1:0]    req_q, req_d, req_in;
  logic [IdxW-1:0]     start_q, start_d, n_w;
  logic [PageW-1:0]    cnt_q, cnt_d;
  logic [SlotW-1:0]    last_q, last_d;
  logic [15:0]         total_q;
  logic [IdxW-1:0]     slots_q;

  logic                res_found_q, res_found_d;
  logic [SlotW-1:0]    res_slot_q, res_slot_d;
  logic [SizeW-1:0]    res_orig_q, res_orig_d, res_rem_q, res_rem_d;
  logic [CntW-1:0]     res_free_q, res_free_d;
  logic [SumW-1:0]     res_unused_q, res_unused_d;
  logic [UsedW-1:0]    res_used_q, res_used_d;

  logic                m_valid_q, m_valid_d, m_user_q, m_user_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  logic                s_acc, inject;
  pfa_wr_t             wr;
  pfa_scan_t           scan;
  logic                tok_vld [SLOTS+1];
  pfa_rec_t            tok     [SLOTS+1];
  pfa_rec_t            rec;
  logic                sel_hit;
  logic [IdxW-1:0]     sel_idx;
  logic [SizeW-1:0]    sel_size;
  logic [PageW-1:0]    page_w;

  assign s_axis_tready = (state_q == StIdle);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign op_in         = pfa_op_e'(s_axis_tuser);
  assign req_in        = SizeW'(SIZE_BITS'(s_axis_tdata[15:0]));
  assign n_w           = (slots_q > SlotCap) ? SlotCap : slots_q;
  assign cfg_ready_o   = 1'b1;

  assign scan.op    = op_q;
  assign scan.req   = req_q;
  assign scan.n     = n_w;
  assign scan.start = start_q;

  assign tok_vld[0] = inject;
  assign tok[0]     = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    pfa_cell #(
      .IDX       (g),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .scan_i      (scan),
      .wr_i        (wr),
      .tok_valid_i (tok_vld[g]),
      .tok_i       (tok[g]),
      .tok_valid_o (tok_vld[g+1]),
      .tok_o       (tok[g+1])
    );
  end

  // Next fit falls back to the first fit below the start when it finds nothing
  assign rec      = tok[SLOTS];
  assign sel_hit  = (op_q == OpNext && !rec.a_hit) ? rec.w_hit  : rec.a_hit;
  assign sel_idx  = (op_q == OpNext && !rec.a_hit) ? rec.w_idx  : rec.a_idx;
  assign sel_size = (op_q == OpNext && !rec.a_hit) ? rec.w_size : rec.a_size;
  assign page_w   = (op_q == OpLoad) ? '0 : cnt_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    req_d        = req_q;
    start_d      = start_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    res_found_d  = res_found_q;
    res_slot_d   = res_slot_q;
    res_orig_d   = res_orig_q;
    res_rem_d    = res_rem_q;
    res_free_d   = res_free_q;
    res_unused_d = res_unused_q;
    res_used_d   = res_used_q;
    m_valid_d    = m_valid_q;
    m_user_d     = m_user_q;
    m_data_d     = m_data_q;
    inject       = 1'b0;
    wr           = '0;

    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    case (state_q)
      StIdle: begin
        if (s_acc) begin
          op_d         = op_in;
          req_d        = req_in;
          res_found_d  = 1'b0;
          res_slot_d   = '0;
          res_orig_d   = '0;
          res_rem_d    = '0;
          res_free_d   = '0;
          res_unused_d = '0;
          res_used_d   = '0;
          if (op_in != OpLoad) cnt_d = cnt_q + PageW'(1);
          case (op_in)
            OpLoad: begin
              wr.en        = 1'b1;
              wr.set_taken = 1'b0;
              wr.idx       = IdxW'(s_axis_tdata[19:16]);
              wr.size      = req_in;
              state_d      = StDone;
            end
            OpFirst, OpBest, OpWorst, OpReport: begin
              start_d = '0;
              state_d = StSetup;
            end
            OpNext: begin
              start_d = IdxW'(last_q) + IdxW'(1);
              state_d = StSetup;
            end
            default: state_d = StDone;
          endcase
        end
      end
      StSetup: begin
        // fold the next-fit start below the scan count, one subtraction a cycle
        if (n_w != '0 && start_q >= n_w) begin
          start_d = start_q - n_w;
        end else begin
          inject  = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        if (tok_vld[SLOTS]) begin
          if (op_q == OpReport) begin
            res_free_d   = rec.free_cnt;
            res_unused_d = rec.unused;
            res_used_d   = UsedW'(total_q) - UsedW'(rec.unused);
          end else if (sel_hit) begin
            res_found_d  = 1'b1;
            res_slot_d   = sel_idx[SlotW-1:0];
            res_orig_d   = sel_size;
            res_rem_d    = sel_size - req_q;
            wr.en        = 1'b1;
            wr.set_taken = 1'b1;
            wr.idx       = sel_idx;
            wr.size      = sel_size - req_q;
            if (op_q == OpFirst || op_q == OpNext) last_d = sel_idx[SlotW-1:0];
          end
          state_d = StDone;
        end
      end
      StDone: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = res_found_q;
          m_data_d  = {6'b0, res_used_q, res_unused_q, res_free_q, page_w,
                       res_rem_q, res_orig_q, res_slot_q};
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      last_q    <= '0;
      total_q   <= '0;
      slots_q   <= 5'd16;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      last_q    <= last_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgTotalMem:   total_q <= cfg_data_i;
          CfgSlotsInUse: slots_q <= cfg_data_i[IdxW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_q        <= req_d;
    start_q      <= start_d;
    res_found_q  <= res_found_d;
    res_slot_q   <= res_slot_d;
    res_orig_q   <= res_orig_d;
    res_rem_q    <= res_rem_d;
    res_free_q   <= res_free_d;
    res_unused_q <= res_unused_d;
    res_used_q   <= res_used_d;
    m_user_q     <= m_user_d;
    m_data_q     <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

  a_token_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_vld[SLOTS] |-> (state_q == StScan))
    else $error("search token left the chain outside a scan");

  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_vld[SLOTS] && rec.a_hit) |-> (rec.a_idx < n_w))
    else $error("chosen partition lies beyond the scan count");

  a_start_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inject |-> ((start_q < n_w) || (n_w == '0)))
    else $error("next-fit start not reduced below the scan count");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && op_in != OpLoad) |=> (cnt_q == $past(cnt_q) + PageW'(1)))
    else $error("request counter missed a step");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for partition_fit_allocator_unit: directed table, then random phases.
// Carries its own allocation predictor and scoreboard; depends on pfa_pkg and the RTL only.
`timescale 1ns / 100ps

module testbench;
  import pfa_pkg::*;

  localparam int SLOTS        = 16;
  localparam int DirLimit     = 5000;  // cycles with no transfer before giving up
  localparam int SettleCycles = 40;    // worst search plus next-fit folding, rounded up
  localparam int PhaseItems   = 50;
  localparam int Phases       = 8;

  // Operation codes beyond the package enum: they only count requests
  localparam logic [2:0] OpSpareA = 3'd6;
  localparam logic [2:0] OpSpareB = 3'd7;

  typedef struct packed {
    logic              found;
    logic [SlotW-1:0]  slot;
    logic [SizeW-1:0]  orig;
    logic [SizeW-1:0]  rem;
    logic [PageW-1:0]  page;
    logic [CntW-1:0]   free;
    logic [SumW-1:0]   unused;
    logic [UsedW-1:0]  used;
  } alloc_result_t;

  typedef struct {
    logic [2:0]        op;
    logic [SizeW-1:0]  size;
    logic [SlotW-1:0]  slot;
    bit                typed;
    alloc_result_t     want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [2:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [15:0]         cfg_data_i = '0;

  // Predictor state: partition table, pointers and register copies
  logic [SizeW-1:0] room [SLOTS];
  bit               held [SLOTS];
  logic [PageW-1:0] owner_page [SLOTS];
  logic [3:0]       last_pick = '0;
  logic [PageW-1:0] page_count = '0;
  logic [15:0]      mem_total = '0;
  logic [4:0]       live_slots = 5'd16;

  alloc_result_t pending_results [$];
  plan_row_t     plan [$];
  int            fail_count = 0;
  int            src_quiet = 0;
  int            sink_quiet = 0;
  int            stall_cycles = 0;

  partition_fit_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      room[i]       = '0;
      held[i]       = 1'b0;
      owner_page[i] = '0;
    end
  end

  function automatic bit slot_fits(input int i, input logic [SizeW-1:0] req);
    return !held[i] && room[i] >= req;
  endfunction

  // Advance the partition table by one item and return the result it gives
  function automatic alloc_result_t predict_alloc(input logic [2:0] op,
                                                  input logic [SizeW-1:0] req,
                                                  input logic [SlotW-1:0] slot);
    alloc_result_t r;
    int            n, start, i, pick, best_left, left;
    bit            hit;
    logic [SumW-1:0] unused;
    r = '0;
    hit = 1'b0;
    pick = 0;
    best_left = 0;
    unused = '0;
    n = (live_slots > SLOTS) ? SLOTS : int'(live_slots);
    if (op == OpLoad) begin
      room[slot]       = req;
      held[slot]       = 1'b0;
      owner_page[slot] = '0;
      return r;
    end
    page_count = page_count + PageW'(1);
    r.page = page_count;
    case (op)
      OpFirst: begin
        for (i = 0; i < n; i++)
          if (!hit && slot_fits(i, req)) begin
            hit = 1'b1;
            pick = i;
          end
      end
      OpBest, OpWorst: begin
        for (i = 0; i < n; i++)
          if (slot_fits(i, req)) begin
            left = int'(room[i]) - int'(req);
            if (!hit || (op == OpBest ? left < best_left : left > best_left)) begin
              hit = 1'b1;
              pick = i;
              best_left = left;
            end
          end
      end
      OpNext: begin
        if (n > 0) begin
          start = (int'(last_pick) + 1) % n;
          for (int k = 0; k < n; k++) begin
            i = (start + k) % n;
            if (!hit && slot_fits(i, req)) begin
              hit = 1'b1;
              pick = i;
            end
          end
        end
      end
      OpReport: begin
        for (i = 0; i < n; i++) begin
          if (!held[i]) r.free = r.free + CntW'(1);
          unused = unused + SumW'(room[i]);
        end
        r.unused = unused;
        r.used = UsedW'(mem_total) - UsedW'(unused);
        return r;
      end
      default: return r;
    endcase
    if (hit) begin
      r.found = 1'b1;
      r.slot  = pick[SlotW-1:0];
      r.orig  = room[pick];
      held[pick]       = 1'b1;
      owner_page[pick] = page_count;
      room[pick]       = room[pick] - req;
      r.rem = room[pick];
      if (op == OpFirst || op == OpNext) last_pick = pick[3:0];
    end
    return r;
  endfunction

  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet = $urandom_range(10, 30);
    return $urandom_range(0, 8);
  endfunction

  task automatic plan_row(input logic [2:0] op, input logic [SizeW-1:0] size,
                          input logic [SlotW-1:0] slot, input bit typed = 1'b0,
                          input alloc_result_t want = '0);
    plan_row_t row;
    row.op = op;
    row.size = size;
    row.slot = slot;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endtask

  // Drive one item; valid stays high afterwards so back-to-back transfers need no dip
  task automatic send_item(input logic [2:0] op, input logic [SizeW-1:0] size,
                           input logic [SlotW-1:0] slot, input bit typed = 1'b0,
                           input alloc_result_t want = '0);
    int            gap;
    alloc_result_t predicted;
    gap = draw_gap(src_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, slot, size};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predicted = predict_alloc(op, size, slot);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic set_config(input logic [15:0] total, input logic [4:0] slots);
    logic [10:0] junk;
    junk = 11'($urandom);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgTotalMem;
    cfg_data_i  <= total;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    mem_total = total;
    cfg_index_i <= CfgSlotsInUse;
    cfg_data_i  <= {junk, slots};
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    live_slots = slots;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  task automatic check_result(input logic found, input logic [OutDataW-1:0] data);
    alloc_result_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result transfer: 0x%0h", data);
      return;
    end
    want = pending_results.pop_front();
    check_field("found", 32'(want.found), 32'(found));
    check_field("slot_index", 32'(want.slot), 32'(data[3:0]));
    check_field("original_size", 32'(want.orig), 32'(data[19:4]));
    check_field("remaining_size", 32'(want.rem), 32'(data[35:20]));
    check_field("page_number", 32'(want.page), 32'(data[51:36]));
    check_field("free_slots", 32'(want.free), 32'(data[56:52]));
    check_field("unused_space", 32'(want.unused), 32'(data[76:57]));
    check_field("used_space", 32'(want.used), 32'(data[97:77]));
  endtask

  // Random item, weighted towards allocations that can land
  task automatic draw_item(output logic [2:0] op, output logic [SizeW-1:0] size,
                           output logic [SlotW-1:0] slot);
    int pick, probe, n;
    n = (live_slots > SLOTS) ? SLOTS : int'(live_slots);
    pick = $urandom_range(0, 99);
    probe = (n > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, n - 1)
                                                  : $urandom_range(0, SLOTS - 1);
    slot = probe[SlotW-1:0];
    if (pick < 30) op = OpLoad;
    else if (pick < 45) op = OpFirst;
    else if (pick < 60) op = OpBest;
    else if (pick < 72) op = OpWorst;
    else if (pick < 85) op = OpNext;
    else if (pick < 95) op = OpReport;
    else op = $urandom_range(0, 1) ? OpSpareA : OpSpareB;
    if (op == OpLoad) begin
      case ($urandom_range(0, 7))
        0:       size = '0;
        1:       size = '1;
        2, 3:    size = SizeW'($urandom_range(0, 255));
        default: size = SizeW'($urandom);
      endcase
    end else begin
      slot = SlotW'($urandom);
      case ($urandom_range(0, 7))
        0:       size = '0;
        1:       size = '1;
        2, 3:    size = room[probe];
        4, 5:    size = SizeW'($urandom_range(0, int'(room[probe])));
        default: size = SizeW'($urandom);
      endcase
    end
  endtask

  initial begin : result_sink
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(sink_quiet);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= DirLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [2:0]       op;
    logic [SizeW-1:0] size;
    logic [SlotW-1:0] slot;
    logic [15:0]      total;
    logic [4:0]       slots;

    // Reset state: 16 partitions of size 0, total memory 0
    plan_row(OpReport, 16'h0000, 4'd0, 1'b1,
             '{1'b0, 4'd0, 16'h0, 16'h0, 16'd1, 5'd16, 20'h0, 21'h0});
    plan_row(OpFirst, 16'h0000, 4'd0, 1'b1,
             '{1'b1, 4'd0, 16'h0, 16'h0, 16'd2, 5'd0, 20'h0, 21'h0});
    plan_row(OpLoad, 16'hFFFF, 4'd0, 1'b1, '0);
    plan_row(OpLoad, 16'h8000, 4'd15, 1'b1, '0);
    plan_row(OpBest, 16'hFFFF, 4'd0, 1'b1,
             '{1'b1, 4'd0, 16'hFFFF, 16'h0, 16'd3, 5'd0, 20'h0, 21'h0});
    plan_row(OpWorst, 16'h0001, 4'd0, 1'b1,
             '{1'b1, 4'd15, 16'h8000, 16'h7FFF, 16'd4, 5'd0, 20'h0, 21'h0});
    // Nothing left that large: fails, only the page counter moves
    plan_row(OpNext, 16'hFFFF, 4'd0, 1'b1,
             '{1'b0, 4'd0, 16'h0, 16'h0, 16'd5, 5'd0, 20'h0, 21'h0});
    plan_row(OpSpareA, 16'hFFFF, 4'd15, 1'b1,
             '{1'b0, 4'd0, 16'h0, 16'h0, 16'd6, 5'd0, 20'h0, 21'h0});
    plan_row(OpSpareB, 16'h0000, 4'd0, 1'b1,
             '{1'b0, 4'd0, 16'h0, 16'h0, 16'd7, 5'd0, 20'h0, 21'h0});
    // Unused exceeds total memory: used space goes negative
    plan_row(OpReport, 16'h0000, 4'd0, 1'b1,
             '{1'b0, 4'd0, 16'h0, 16'h0, 16'd8, 5'd14, 20'h07FFF, 21'h1F8001});
    plan_row(OpLoad, 16'd300, 4'd3);
    plan_row(OpLoad, 16'd100, 4'd5);
    plan_row(OpLoad, 16'd100, 4'd9);
    plan_row(OpLoad, 16'd100, 4'd12);
    plan_row(OpBest, 16'd40, 4'd0);     // tie on leftover: lowest index wins
    plan_row(OpWorst, 16'd100, 4'd0);
    plan_row(OpWorst, 16'd100, 4'd0);   // exact fits only
    plan_row(OpNext, 16'd1, 4'd0);
    plan_row(OpNext, 16'd0, 4'd0);
    plan_row(OpNext, 16'd0, 4'd0);
    plan_row(OpNext, 16'd0, 4'd0);      // wraps past the top slot
    plan_row(OpFirst, 16'h0010, 4'd0);
    plan_row(OpReport, 16'h0000, 4'd0);
    plan_row(OpLoad, 16'h0000, 4'd15);  // load frees a taken slot
    plan_row(OpReport, 16'h0000, 4'd0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i])
      send_item(plan[i].op, plan[i].size, plan[i].slot, plan[i].typed, plan[i].want);
    s_axis_tvalid <= 1'b0;

    for (int phase = 0; phase < Phases; phase++) begin
      drain_results();
      case (phase)
        0:       begin total = 16'hFFFF;  slots = 5'd16; end
        1:       begin total = 16'h0000;  slots = 5'd1;  end
        2:       begin total = 16'($urandom); slots = 5'($urandom_range(1, 16)); end
        3:       begin total = 16'($urandom); slots = 5'd0;  end
        4:       begin total = 16'hFFFF;  slots = 5'd31; end
        5:       begin total = 16'($urandom); slots = 5'($urandom_range(2, 16)); end
        6:       begin total = 16'($urandom); slots = 5'd17; end
        default: begin total = 16'h0000;  slots = 5'd16; end
      endcase
      set_config(total, slots);
      for (int k = 0; k < PhaseItems; k++) begin
        draw_item(op, size, slot);
        send_item(op, size, slot);
      end
      s_axis_tvalid <= 1'b0;
    end

    drain_results();
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
